/* rtl/slest_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types for the stochastic length event step block.
package slest_pkg;

  localparam int MAX_CARRIERS_DEF = 64;
  localparam int MAX_LENGTH_DEF   = 1023;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int RATE_W      = 10;
  localparam int TIME_W      = 48;
  localparam int EXP_W       = 32;
  localparam int SEL_W       = 16;
  localparam int STATUS_W    = 3;
  localparam int CIDX_W      = 6;
  localparam int SPOS_W      = 11;
  localparam int TRACK_W     = 10;
  localparam int CNT_CHG_W   = 32;
  localparam int ACT_W       = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FWD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BWD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHRINK   = 3'd5;

  localparam logic FUNC_LOAD = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED   = 3'd0,
    ST_MOVED    = 3'd1,
    ST_GREW     = 3'd2,
    ST_SHRANK   = 3'd3,
    ST_LIMIT    = 3'd4,
    ST_FINISHED = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SUM, S_TOTAL, S_DIV, S_TCHK, S_WALK, S_MOVE, S_SHIFT, S_OUT
  } fsm_t;

endpackage

/* rtl/slest_pos_mem.sv */
`timescale 1ns / 1ps
// Carrier position memory: one write port, one registered read port.
module slest_pos_mem import slest_pkg::*; #(
  parameter int DEPTH = MAX_CARRIERS_DEF,
  parameter int AW    = 6,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/slest_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module slest_div import slest_pkg::*; #(
  parameter int DIV_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [EXP_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [EXP_W-1:0] quotient
);

  localparam int STEP_W = $clog2(EXP_W + 1);

  logic [DIV_W:0]      rem_r;
  logic [EXP_W-1:0]    q_r;
  logic [DIV_W-1:0]    dvs_r;
  logic [STEP_W-1:0]   step_r;
  logic                busy_r;
  logic [DIV_W:0]      rem_sh;
  logic                ge;

  assign rem_sh   = {rem_r[DIV_W-1:0], q_r[EXP_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs_r};
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(EXP_W - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      q_r   <= {q_r[EXP_W-2:0], ge};
    end
  end

endmodule

/* rtl/stochastic_length_event_step_top.sv */
`timescale 1ns / 1ps
// Top level of the stochastic length event step block.
//
// Input channel (in_valid / in_stall): one item per request. func low loads
// one carrier position and restarts the run; func high performs one event
// step. Result channel (out_valid / out_stall): exactly one item per input.
// Configuration (cfg_we / cfg_idx / cfg_wdata) is to be written by the user
// only while idle; the block itself does not enforce this. Items are taken
// one at a time; in_stall stays high until the result is placed in the
// output register. A step item makes one pass over the position memory for
// the rate sum, a run of the serial divider, one pass for the event pick
// and, on a shrink, one read-modify-write pass for the edge shift; the single
// read port of the position memory sets the pass length.
// After reset the run is finished, time, length and change count are zero
// and the registers hold their defaults; carrier positions are unknown until
// loaded. When the receiver stalls, the result holds in the output register
// and the next item may already be accepted and worked on; it waits for the
// slot before its own result is shown.
module stochastic_length_event_step_top import slest_pkg::*; #(
  parameter int MAX_CARRIERS = MAX_CARRIERS_DEF,
  parameter int MAX_LENGTH   = MAX_LENGTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic [CIDX_W-1:0]       in_carrier_index,
  input  logic signed [SPOS_W-1:0] in_start_position,
  input  logic [SEL_W-1:0]        in_select_draw,
  input  logic [EXP_W-1:0]        in_exp_draw,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic [CIDX_W-1:0]       out_moved_carrier,
  output logic [TRACK_W-1:0]      out_track_length,
  output logic [TIME_W-1:0]       out_sim_time,
  output logic [CNT_CHG_W-1:0]    out_change_count,
  output logic                    out_record_point
);

  localparam int AW     = (MAX_CARRIERS > 1) ? $clog2(MAX_CARRIERS) : 1;
  localparam int CNT_W  = $clog2(MAX_CARRIERS + 1);
  localparam int CMP_W  = (CNT_W > ACT_W) ? CNT_W : ACT_W;
  localparam int LEN_W0 = $clog2(MAX_LENGTH + 1);
  localparam int LEN_W  = (LEN_W0 > TRACK_W) ? LEN_W0 : TRACK_W;
  localparam int POS_W  = LEN_W + 1;
  localparam int TOT_W  = $clog2((MAX_CARRIERS + 1) * 1023 + 1);
  localparam int TGT_W  = TOT_W + SEL_W;

  // configuration
  logic [ACT_W-1:0]   active_r;
  logic [TRACK_W-1:0] init_len_r;
  logic [TIME_W-1:0]  limit_r;
  logic [RATE_W-1:0]  fwd_r, bwd_r, shrink_r;

  // captured item
  logic              func_r;
  logic [CIDX_W-1:0] cidx_r;
  logic [SPOS_W-1:0] spos_r;
  logic [SEL_W-1:0]  sel_r;
  logic [EXP_W-1:0]  exp_r;

  // run state
  logic [LEN_W-1:0]     len_r;
  logic [TIME_W-1:0]    time_r;
  logic [CNT_CHG_W-1:0] chg_r;
  logic                 fin_r;

  // working registers
  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic              pend_r;
  logic [AW-1:0]     pend_idx_r;
  logic [TOT_W-1:0]  total_r;
  logic [TOT_W-1:0]  prefix_r;
  logic [TIME_W:0]   tsum_r;
  logic [TGT_W-1:0]  target_r;
  logic [POS_W-1:0]  mpos_r;
  logic [AW-1:0]     carrier_r;
  status_t           status_r;
  logic              rec_r;

  // output register
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [CIDX_W-1:0]    out_carrier_r;
  logic [TRACK_W-1:0]   out_len_r;
  logic [TIME_W-1:0]    out_time_r;
  logic [CNT_CHG_W-1:0] out_chg_r;
  logic                 out_rec_r;

  // memory port
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [POS_W-1:0] rd_data, wr_data;

  logic [CNT_W-1:0] n_c;
  logic             issue;
  logic             out_free;
  logic [TOT_W-1:0] rate_c;
  logic [TOT_W-1:0] pfx_c;
  logic             hit_c;
  logic [EXP_W-1:0] tau;
  logic             div_start, div_done;
  logic [TOT_W-1:0] tot_c;
  logic signed [POS_W:0] np_c, len_s, shpos_c;
  logic             load_ok;

  assign n_c = (CMP_W'(active_r) > CMP_W'(MAX_CARRIERS)) ? CNT_W'(MAX_CARRIERS)
                                                         : CNT_W'(active_r);
  assign issue    = rd_cnt_r < n_c;
  assign out_free = !out_valid_r || !out_stall;
  assign rate_c   = rd_data[POS_W-1] ? TOT_W'(bwd_r) : TOT_W'(fwd_r);
  assign pfx_c    = prefix_r + rate_c;
  assign hit_c    = {pfx_c, {SEL_W{1'b0}}} > target_r;
  assign tot_c    = total_r + ((len_r != '0) ? TOT_W'(shrink_r) : '0);
  assign np_c     = $signed({mpos_r[POS_W-1], mpos_r}) + (POS_W + 1)'(1);
  assign len_s    = $signed({2'b00, len_r});
  assign shpos_c  = $signed({rd_data[POS_W-1], rd_data});
  assign load_ok  = (CNT_W + CIDX_W)'(cidx_r) < (CNT_W + CIDX_W)'(MAX_CARRIERS);

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_moved_carrier = out_carrier_r;
  assign out_track_length  = out_len_r;
  assign out_sim_time      = out_time_r;
  assign out_change_count  = out_chg_r;
  assign out_record_point  = out_rec_r;

  slest_pos_mem #(.DEPTH(MAX_CARRIERS), .AW(AW), .DW(POS_W)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // divisor is sampled on start, while the full total is still combinational
  slest_div #(.DIV_W(TOT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (exp_r),
    .divisor  (tot_c),
    .done     (div_done),
    .quotient (tau)
  );

  // next state and memory control
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = rd_cnt_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = pend_idx_r;
    wr_data   = rd_data;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (func_r == FUNC_LOAD) begin
          wr_en     = load_ok;
          wr_addr   = AW'(cidx_r);
          wr_data   = POS_W'($signed(spos_r));
          state_nxt = S_OUT;
        end else if (fin_r || time_r >= limit_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        rd_en = issue;
        if (!issue && !pend_r) state_nxt = S_TOTAL;
      end
      S_TOTAL: begin
        if (tot_c == '0) begin
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_TCHK;
      end
      S_TCHK: begin
        state_nxt = (tsum_r > {1'b0, limit_r}) ? S_OUT : S_WALK;
      end
      S_WALK: begin
        rd_en = issue;
        if (pend_r && hit_c) state_nxt = S_MOVE;
        else if (!issue && !pend_r) state_nxt = S_SHIFT;
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = carrier_r;
        if (np_c > len_s) begin
          wr_data = (len_r >= LEN_W'(MAX_LENGTH)) ? POS_W'(-len_s) : POS_W'(-(len_s + 1));
        end else begin
          wr_data = POS_W'(np_c);
        end
        state_nxt = S_OUT;
      end
      S_SHIFT: begin
        rd_en = issue;
        if (pend_r) begin
          // carriers sitting at either edge follow the tip inward
          if (shpos_c == len_s + 1) begin
            wr_en   = 1'b1;
            wr_data = POS_W'(shpos_c - 1);
          end else if (shpos_c == -len_s - 1) begin
            wr_en   = 1'b1;
            wr_data = POS_W'(shpos_c + 1);
          end
        end
        if (!issue && !pend_r) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACT_W'(1);
      init_len_r  <= '0;
      limit_r     <= TIME_W'(65536);
      fwd_r       <= RATE_W'(200);
      bwd_r       <= RATE_W'(350);
      shrink_r    <= RATE_W'(1);
      len_r       <= '0;
      time_r      <= '0;
      chg_r       <= '0;
      fin_r       <= 1'b1;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      rd_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_ACTIVE:   active_r   <= cfg_wdata[ACT_W-1:0];
          REG_INIT_LEN: init_len_r <= cfg_wdata[TRACK_W-1:0];
          REG_LIMIT:    limit_r    <= cfg_wdata[TIME_W-1:0];
          REG_FWD:      fwd_r      <= cfg_wdata[RATE_W-1:0];
          REG_BWD:      bwd_r      <= cfg_wdata[RATE_W-1:0];
          REG_SHRINK:   shrink_r   <= cfg_wdata[RATE_W-1:0];
          default: ;
        endcase
      end
      // output slot: refill wins over the drain of the previous item
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        S_DISPATCH: begin
          rd_cnt_r <= '0;
          pend_r   <= 1'b0;
          if (func_r == FUNC_LOAD) begin
            len_r  <= LEN_W'(init_len_r);
            time_r <= '0;
            chg_r  <= '0;
            fin_r  <= 1'b0;
          end else if (fin_r || time_r >= limit_r) begin
            fin_r <= 1'b1;
          end
        end
        S_SUM, S_WALK, S_SHIFT: begin
          if (state_r == S_WALK && pend_r && hit_c) begin
            pend_r <= 1'b0;
          end else if (state_r == S_WALK && !issue && !pend_r) begin
            // no carrier picked: the track shrinks
            len_r    <= len_r - 1'b1;
            chg_r    <= chg_r + 1'b1;
            rd_cnt_r <= '0;
          end else begin
            if (issue) rd_cnt_r <= rd_cnt_r + 1'b1;
            pend_r <= issue;
          end
          if (state_r == S_SHIFT && !issue && !pend_r) begin
            time_r <= tsum_r[TIME_W-1:0];
            fin_r  <= (tsum_r == {1'b0, limit_r});
          end
        end
        S_TOTAL: begin
          if (tot_c == '0) begin
            time_r <= limit_r;
            fin_r  <= 1'b1;
          end
        end
        S_TCHK: begin
          rd_cnt_r <= '0;
          pend_r   <= 1'b0;
          if (tsum_r > {1'b0, limit_r}) begin
            time_r <= limit_r;
            fin_r  <= 1'b1;
          end
        end
        S_MOVE: begin
          if (np_c > len_s && len_r < LEN_W'(MAX_LENGTH)) begin
            len_r <= len_r + 1'b1;
            chg_r <= chg_r + 1'b1;
          end
          time_r <= tsum_r[TIME_W-1:0];
          fin_r  <= (tsum_r == {1'b0, limit_r});
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      func_r <= in_func;
      cidx_r <= in_carrier_index;
      spos_r <= in_start_position;
      sel_r  <= in_select_draw;
      exp_r  <= in_exp_draw;
    end
    if (state_r == S_OUT && out_free) begin
      out_status_r  <= status_r;
      out_carrier_r <= CIDX_W'(carrier_r);
      out_len_r     <= TRACK_W'(len_r);
      out_time_r    <= time_r;
      out_chg_r     <= chg_r;
      out_rec_r     <= rec_r;
    end
    if (state_r == S_SUM && pend_r) total_r <= total_r + rate_c;
    if (state_r == S_WALK && pend_r) begin
      prefix_r   <= pfx_c;
      carrier_r  <= pend_idx_r;
      mpos_r     <= rd_data;
    end
    if (rd_en) pend_idx_r <= rd_addr;
    if (state_r == S_DIV && div_done) begin
      tsum_r   <= {1'b0, time_r} + (TIME_W + 1)'(tau);
      target_r <= TGT_W'(total_r) * TGT_W'(sel_r);
    end
    case (state_r)
      S_DISPATCH: begin
        total_r   <= '0;
        carrier_r <= '0;
        rec_r     <= 1'b0;
        status_r  <= (func_r == FUNC_LOAD) ? ST_LOADED : ST_FINISHED;
      end
      S_TOTAL: begin
        total_r  <= tot_c;
        status_r <= ST_LIMIT;
        rec_r    <= 1'b1;
      end
      S_TCHK: begin
        prefix_r <= '0;
        status_r <= ST_LIMIT;
        rec_r    <= 1'b1;
      end
      S_WALK: begin
        if (!issue && !pend_r) begin
          status_r  <= ST_SHRANK;
          rec_r     <= 1'b1;
          carrier_r <= '0;
        end
      end
      S_MOVE: begin
        if (np_c > len_s) begin
          if (len_r >= LEN_W'(MAX_LENGTH)) begin
            status_r <= ST_OVERFLOW;
            rec_r    <= (tsum_r == {1'b0, limit_r});
          end else begin
            status_r <= ST_GREW;
            rec_r    <= 1'b1;
          end
        end else begin
          status_r <= ST_MOVED;
          rec_r    <= (tsum_r == {1'b0, limit_r});
        end
      end
      default: ;
    endcase
  end

endmodule
